// ===== rtl/bssw_pkg.sv =====
// Shared constants and types of the bit stream sync word receiver.
`default_nettype none
package bssw_pkg;

   localparam int WORD_BITS    = 16;
   localparam int PREFIX_BITS  = 4;
   localparam int COUNT_BITS   = 4;
   localparam int PAYLOAD_BITS = 12;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [PREFIX_BITS-1:0] SYNC_PREFIX_RESET    = 4'b1110;
   localparam logic [WORD_BITS-1:0]   INITIAL_TARGET_RESET = 16'h0000;
   localparam logic [WORD_BITS-1:0]   COUNTER_MAX          = 16'hFFFF;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_PREFIX    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_TARGET = 1'b1;

   typedef struct packed {
      logic                 word_valid;
      logic [WORD_BITS-1:0] window;
   } frame_info_type;

   typedef struct packed {
      logic                 word_valid;
      logic [WORD_BITS-1:0] found_word;
      logic                 after_valid;
      logic [WORD_BITS-1:0] bits_after_event;
      logic                 event_seen;
      logic [WORD_BITS-1:0] event_newest_word;
      logic [WORD_BITS-1:0] event_previous_word;
      logic                 target_match;
      logic                 flag_level;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/bssw_channels.sv =====
// Valid/ready channel interfaces for received bits and results.
`default_nettype none
interface bssw_req_if;
   logic                           valid;
   logic                           ready;
   logic                           data_bit;
   logic                           pin_level;
   logic [bssw_pkg::WORD_BITS-1:0] next_target;

   modport source (output valid, data_bit, pin_level, next_target, input ready);
   modport sink   (input valid, data_bit, pin_level, next_target, output ready);
endinterface

interface bssw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           word_valid;
   logic [bssw_pkg::WORD_BITS-1:0] found_word;
   logic                           after_valid;
   logic [bssw_pkg::WORD_BITS-1:0] bits_after_event;
   logic                           event_seen;
   logic [bssw_pkg::WORD_BITS-1:0] event_newest_word;
   logic [bssw_pkg::WORD_BITS-1:0] event_previous_word;
   logic                           target_match;
   logic                           flag_level;

   modport source (output valid, word_valid, found_word, after_valid, bits_after_event,
                   event_seen, event_newest_word, event_previous_word, target_match,
                   flag_level, input ready);
   modport sink   (input valid, word_valid, found_word, after_valid, bits_after_event,
                   event_seen, event_newest_word, event_previous_word, target_match,
                   flag_level, output ready);
endinterface
`default_nettype wire

// ===== rtl/bssw_framer.sv =====
// Bit window shifter and sync prefix framer.
`default_nettype none
module bssw_framer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic                             data_bit,
   input  wire logic [bssw_pkg::PREFIX_BITS-1:0] sync_prefix,
   output bssw_pkg::frame_info_type              frame
);

   logic [bssw_pkg::WORD_BITS-1:0]  window_ff, window_in;
   logic                            hunting_ff, hunting_in;
   logic [bssw_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [bssw_pkg::COUNT_BITS-1:0] count_inc;
   logic                            word_valid;

   always_comb begin
      window_in  = {window_ff[bssw_pkg::WORD_BITS-2:0], data_bit};
      count_inc  = count_ff + bssw_pkg::COUNT_BITS'(1);
      hunting_in = hunting_ff;
      count_in   = count_ff;
      word_valid = 1'b0;
      if (window_in[bssw_pkg::PREFIX_BITS-1:0] == sync_prefix) begin
         hunting_in = 1'b1;
         count_in   = '0;
      end else if (hunting_ff) begin
         count_in = count_inc;
         if (count_inc == bssw_pkg::COUNT_BITS'(bssw_pkg::PAYLOAD_BITS)) begin
            hunting_in = 1'b0;
            word_valid = 1'b1;
         end
      end
   end

   assign frame.word_valid = word_valid;
   assign frame.window     = window_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= '0;
         hunting_ff <= 1'b0;
         count_ff   <= '0;
      end else if (advance) begin
         window_ff  <= window_in;
         hunting_ff <= hunting_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bssw_event_tracker.sv =====
// Word history, pin event detection, bit counter and target flag logic.
`default_nettype none
module bssw_event_tracker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           pin_level,
   input  wire logic [bssw_pkg::WORD_BITS-1:0] next_target,
   input  wire bssw_pkg::frame_info_type       frame,
   input  wire logic                           target_load,
   input  wire logic [bssw_pkg::WORD_BITS-1:0] target_value,
   output bssw_pkg::result_type                result
);

   localparam int W = bssw_pkg::WORD_BITS;

   logic [2*W-1:0] history_ff, history_in;
   logic           pending_ff, pending_in;
   logic [W-1:0]   counter_ff, counter_in;
   logic           parity_ff, parity_in;
   logic           flag_ff, flag_in;
   logic [W-1:0]   target_ff, target_in;
   logic [W-1:0]   counter_inc;
   logic           event_hit;

   always_comb begin
      counter_inc = (counter_ff == bssw_pkg::COUNTER_MAX) ? counter_ff
                                                          : counter_ff + W'(1);
      history_in = frame.word_valid ? {history_ff[W-1:0], frame.window} : history_ff;
      pending_in = frame.word_valid ? 1'b0 : pending_ff;
      counter_in = counter_inc;
      parity_in  = parity_ff;
      flag_in    = flag_ff;
      target_in  = target_ff;
      event_hit  = pin_level ^ parity_ff;

      result                     = '0;
      result.word_valid          = frame.word_valid;
      result.found_word          = frame.word_valid ? frame.window : '0;
      if (frame.word_valid && pending_ff) begin
         result.after_valid      = 1'b1;
         result.bits_after_event = counter_inc;
      end

      if (event_hit) begin
         parity_in                  = ~parity_ff;
         pending_in                 = 1'b1;
         counter_in                 = '0;
         result.event_seen          = 1'b1;
         result.event_newest_word   = history_in[W-1:0];
         result.event_previous_word = history_in[2*W-1:W];
      end else if (frame.window == target_ff) begin
         result.target_match = 1'b1;
         flag_in             = ~flag_ff;
         target_in           = next_target;
      end
      result.flag_level = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         pending_ff <= 1'b0;
         counter_ff <= '0;
         parity_ff  <= 1'b0;
         flag_ff    <= 1'b0;
         target_ff  <= bssw_pkg::INITIAL_TARGET_RESET;
      end else if (target_load) begin
         target_ff <= target_value;
      end else if (advance) begin
         history_ff <= history_in;
         pending_ff <= pending_in;
         counter_ff <= counter_in;
         parity_ff  <= parity_in;
         flag_ff    <= flag_in;
         target_ff  <= target_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bit_stream_sync_word_receiver_top.sv =====
// Each accepted bit's result is registered and shown on rsp in the next cycle.
// Throughput: one bit per cycle; the single result register sets the rate and
// accepts a new bit whenever it is empty or is being drained in the same cycle.
// Reset: synchronous, clears all framing, history, counter and flag state and the result
// valid flag, restores the sync prefix to 4'b1110 and the target to zero.
`default_nettype none
module bit_stream_sync_word_receiver_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bssw_req_if.sink                                 req,
   bssw_rsp_if.source                               rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [bssw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [bssw_pkg::WORD_BITS-1:0]      csr_write_data
);

   logic [bssw_pkg::PREFIX_BITS-1:0] sync_prefix_ff;
   logic                             target_load;
   logic                             accept;
   logic                             rsp_valid_ff;
   bssw_pkg::result_type             result;
   bssw_pkg::result_type             result_ff;
   bssw_pkg::frame_info_type         frame;

   assign req.ready   = ~rsp_valid_ff | rsp.ready;
   assign accept      = req.valid & req.ready;
   assign target_load = csr_write_enable && (csr_index == bssw_pkg::CSR_INITIAL_TARGET);

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_prefix_ff <= bssw_pkg::SYNC_PREFIX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bssw_pkg::CSR_SYNC_PREFIX:
               sync_prefix_ff <= csr_write_data[bssw_pkg::PREFIX_BITS-1:0];
            default: ;
         endcase
      end
   end

   bssw_framer u_framer (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .data_bit    (req.data_bit),
      .sync_prefix (sync_prefix_ff),
      .frame       (frame)
   );

   bssw_event_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .pin_level    (req.pin_level),
      .next_target  (req.next_target),
      .frame        (frame),
      .target_load  (target_load),
      .target_value (csr_write_data),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.word_valid          = result_ff.word_valid;
   assign rsp.found_word          = result_ff.found_word;
   assign rsp.after_valid         = result_ff.after_valid;
   assign rsp.bits_after_event    = result_ff.bits_after_event;
   assign rsp.event_seen          = result_ff.event_seen;
   assign rsp.event_newest_word   = result_ff.event_newest_word;
   assign rsp.event_previous_word = result_ff.event_previous_word;
   assign rsp.target_match        = result_ff.target_match;
   assign rsp.flag_level          = result_ff.flag_level;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the bit stream sync word receiver: directed table, random frames.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int HOLD_CYCLES = 200;
   localparam int STREAM_BITS = 300;

   typedef struct packed {
      logic                           data_bit;
      logic                           pin_level;
      logic [bssw_pkg::WORD_BITS-1:0] next_target;
      logic                           literal_on;
      bssw_pkg::result_type           literal;
   } stim_row_type;

   localparam bssw_pkg::result_type RESULT_NONE = '0;
   localparam bssw_pkg::result_type AFTER_RESET_MATCH =
      {1'b0, 16'h0000, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1};
   localparam bssw_pkg::result_type FIRST_EVENT =
      {1'b0, 16'h0000, 1'b0, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1};

   localparam stim_row_type DIRECTED_ROWS [23] = '{
      {1'b0, 1'b0, 16'hEFFF, 1'b1, AFTER_RESET_MATCH},
      {1'b1, 1'b1, 16'h0000, 1'b1, FIRST_EVENT},
      {1'b1, 1'b1, 16'hFFFF, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h8001, 1'b0, RESULT_NONE},
      {1'b0, 1'b1, 16'h0000, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h7FFE, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'hAAAA, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h5555, 1'b0, RESULT_NONE},
      {1'b0, 1'b1, 16'hFFFF, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h0123, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h4567, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h89AB, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'hCDEF, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'hFEDC, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'hBA98, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h7654, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h3210, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h0F0F, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'hF0F0, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h00FF, 1'b0, RESULT_NONE},
      {1'b1, 1'b0, 16'hFF00, 1'b0, RESULT_NONE},
      {1'b0, 1'b0, 16'h1234, 1'b0, RESULT_NONE},
      {1'b1, 1'b1, 16'h0000, 1'b0, RESULT_NONE}
   };

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [bssw_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [bssw_pkg::WORD_BITS-1:0]      csr_write_data;

   bssw_req_if req_ch ();
   bssw_rsp_if rsp_ch ();

   bit_stream_sync_word_receiver_top dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [bssw_pkg::PREFIX_BITS-1:0] prefix_copy      = bssw_pkg::SYNC_PREFIX_RESET;
   logic [bssw_pkg::WORD_BITS-1:0]   armed_target     = bssw_pkg::INITIAL_TARGET_RESET;
   logic [bssw_pkg::WORD_BITS-1:0]   shift_window     = '0;
   logic                             in_frame         = 1'b0;
   logic [bssw_pkg::COUNT_BITS-1:0]  frame_count      = '0;
   logic [bssw_pkg::WORD_BITS-1:0]   newest_word      = '0;
   logic [bssw_pkg::WORD_BITS-1:0]   older_word       = '0;
   logic                             report_next_word = 1'b0;
   logic [bssw_pkg::WORD_BITS-1:0]   event_distance   = '0;
   logic                             pin_phase        = 1'b0;
   logic                             flag_copy        = 1'b0;

   bssw_pkg::result_type predicted_results [$];

   bssw_pkg::result_type                literal_q;
   logic                                literal_on_q;
   logic                                stim_pin = 1'b0;
   logic [bssw_pkg::PAYLOAD_BITS-1:0]   payload_pool [4];
   bit                                  calm = 1'b0;
   bit                                  hold_request = 1'b0;
   int                                  sender_gap_pct = 0;
   int unsigned                         items_sent = 0;
   int unsigned                         mismatch_count = 0;
   int unsigned                         cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic bssw_pkg::result_type predict_result(
         input logic data_bit, input logic pin_level,
         input logic [bssw_pkg::WORD_BITS-1:0] next_target);
      bssw_pkg::result_type r;
      r = '0;
      shift_window = {shift_window[bssw_pkg::WORD_BITS-2:0], data_bit};
      if (event_distance != bssw_pkg::COUNTER_MAX) event_distance = event_distance + 1'b1;

      if (shift_window[bssw_pkg::PREFIX_BITS-1:0] == prefix_copy) begin
         in_frame    = 1'b1;
         frame_count = '0;
      end else if (in_frame) begin
         frame_count = frame_count + 1'b1;
         if (frame_count == bssw_pkg::PAYLOAD_BITS) begin
            in_frame     = 1'b0;
            r.word_valid = 1'b1;
            r.found_word = shift_window;
         end
      end

      if (r.word_valid) begin
         older_word  = newest_word;
         newest_word = shift_window;
         if (report_next_word) begin
            r.after_valid      = 1'b1;
            r.bits_after_event = event_distance;
            report_next_word   = 1'b0;
         end
      end

      // event fires on any pin level change
      if (pin_level != pin_phase) begin
         pin_phase             = pin_level;
         r.event_seen          = 1'b1;
         r.event_newest_word   = newest_word;
         r.event_previous_word = older_word;
         report_next_word      = 1'b1;
         event_distance        = '0;
      end else if (shift_window == armed_target) begin
         r.target_match = 1'b1;
         flag_copy      = ~flag_copy;
         armed_target   = next_target;
      end
      r.flag_level = flag_copy;
      return r;
   endfunction

   function automatic string describe_result(input bssw_pkg::result_type r);
      return $sformatf("word %b/%h after %b/%0d event %b/%h/%h match %b flag %b",
                       r.word_valid, r.found_word, r.after_valid, r.bits_after_event,
                       r.event_seen, r.event_newest_word, r.event_previous_word,
                       r.target_match, r.flag_level);
   endfunction

   function automatic logic [bssw_pkg::WORD_BITS-1:0] next_frame_word();
      return {prefix_copy, $urandom_range(0, 1) ? payload_pool[$urandom_range(0, 3)]
                                                : bssw_pkg::PAYLOAD_BITS'($urandom)};
   endfunction

   always @(posedge clock) begin : scoreboard
      bssw_pkg::result_type observed;
      bssw_pkg::result_type wanted;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            wanted = predict_result(req_ch.data_bit, req_ch.pin_level, req_ch.next_target);
            if (literal_on_q) wanted = literal_q;
            predicted_results.push_back(wanted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            observed = {rsp_ch.word_valid, rsp_ch.found_word, rsp_ch.after_valid,
                        rsp_ch.bits_after_event, rsp_ch.event_seen, rsp_ch.event_newest_word,
                        rsp_ch.event_previous_word, rsp_ch.target_match, rsp_ch.flag_level};
            if (predicted_results.size() == 0) begin
               if (mismatch_count < 10)
                  $display("cycle %0d: unexpected result %s", cycle_count,
                           describe_result(observed));
               mismatch_count++;
            end else begin
               wanted = predicted_results.pop_front();
               if (observed !== wanted) begin
                  if (mismatch_count < 10)
                     $display("cycle %0d: result mismatch\n  expected %s\n  actual   %s",
                              cycle_count, describe_result(wanted), describe_result(observed));
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin : receiver
      int stall_pct;
      stall_pct = 20;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         if ($urandom_range(0, 15) == 0) stall_pct = 20 * $urandom_range(0, 2);
      end
   end

   task automatic send_bit(input logic d, input logic p,
                           input logic [bssw_pkg::WORD_BITS-1:0] nt,
                           input logic lit_on, input bssw_pkg::result_type lit);
      if (items_sent % 64 == 0) sender_gap_pct = 15 * $urandom_range(0, 2);
      items_sent++;
      if (!calm && $urandom_range(0, 99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_bit    <= d;
      req_ch.pin_level   <= p;
      req_ch.next_target <= nt;
      literal_on_q       <= lit_on;
      literal_q          <= lit;
      stim_pin = p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [bssw_pkg::CSR_INDEX_BITS-1:0] reg_index,
                            input logic [bssw_pkg::WORD_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= value;
      @(posedge clock);
      case (reg_index)
         bssw_pkg::CSR_SYNC_PREFIX:    prefix_copy  = value[bssw_pkg::PREFIX_BITS-1:0];
         bssw_pkg::CSR_INITIAL_TARGET: armed_target = value;
         default: ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // frames with random payloads; next_target mostly names the frame after the current one
   task automatic run_stream(input int n_bits, input bit seed_target, input bit with_hold);
      logic [bssw_pkg::WORD_BITS-1:0] word;
      logic [bssw_pkg::WORD_BITS-1:0] upcoming;
      logic [bssw_pkg::WORD_BITS-1:0] hint;
      int sent;
      int kind;
      int len;
      for (int i = 0; i < 4; i++) payload_pool[i] = bssw_pkg::PAYLOAD_BITS'($urandom);
      upcoming = next_frame_word();
      if (seed_target) csr_write(bssw_pkg::CSR_INITIAL_TARGET, upcoming);
      sent = 0;
      while (sent < n_bits) begin
         word     = upcoming;
         upcoming = next_frame_word();
         kind     = $urandom_range(0, 9);
         if (kind < 8) len = bssw_pkg::WORD_BITS;
         else if (kind == 8) len = $urandom_range(1, 6);
         else len = bssw_pkg::PREFIX_BITS + $urandom_range(1, bssw_pkg::PAYLOAD_BITS - 1);
         for (int i = 0; i < len; i++) begin
            hint = ($urandom_range(0, 3) != 0) ? upcoming
                                               : bssw_pkg::WORD_BITS'($urandom);
            send_bit((kind == 8) ? 1'($urandom) : word[bssw_pkg::WORD_BITS-1-i],
                     stim_pin ^ ($urandom_range(0, 23) == 0), hint, 1'b0, RESULT_NONE);
            sent++;
            if (with_hold && sent == n_bits / 2) hold_request = 1'b1;
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid       <= 1'b0;
      req_ch.data_bit    <= 1'b0;
      req_ch.pin_level   <= 1'b0;
      req_ch.next_target <= '0;
      literal_on_q       <= 1'b0;
      literal_q          <= RESULT_NONE;
      csr_write_enable   <= 1'b0;
      csr_index          <= bssw_pkg::CSR_SYNC_PREFIX;
      csr_write_data     <= '0;
      reset              <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++)
         send_bit(DIRECTED_ROWS[i].data_bit, DIRECTED_ROWS[i].pin_level,
                  DIRECTED_ROWS[i].next_target, DIRECTED_ROWS[i].literal_on,
                  DIRECTED_ROWS[i].literal);
      wait_drained();

      csr_write(bssw_pkg::CSR_SYNC_PREFIX, bssw_pkg::WORD_BITS'(4'h0));
      csr_write(bssw_pkg::CSR_INITIAL_TARGET, 16'h0000);
      run_stream(STREAM_BITS, 1'b0, 1'b0);
      wait_drained();

      csr_write(bssw_pkg::CSR_SYNC_PREFIX, bssw_pkg::WORD_BITS'(4'hF));
      csr_write(bssw_pkg::CSR_INITIAL_TARGET, 16'hFFFF);
      run_stream(STREAM_BITS, 1'b0, 1'b1);
      wait_drained();

      csr_write(bssw_pkg::CSR_SYNC_PREFIX, bssw_pkg::WORD_BITS'($urandom_range(0, 15)));
      run_stream(STREAM_BITS, 1'b1, 1'b0);
      wait_drained();

      calm = 1'b1;
      csr_write(bssw_pkg::CSR_SYNC_PREFIX, bssw_pkg::WORD_BITS'($urandom_range(0, 15)));
      run_stream(STREAM_BITS, 1'b1, 1'b0);
      wait_drained();
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bssw_pkg.sv
rtl/bssw_channels.sv
rtl/bssw_framer.sv
rtl/bssw_event_tracker.sv
rtl/bit_stream_sync_word_receiver_top.sv
tb/testbench.sv
